### design/assert_macros.svh
// Assertion macros shared by the union-find edge filter RTL.
// Needs nothing else; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define UFEF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define UFEF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/ufef_pkg.sv
// Package for the union-find edge filter: sizes, state encoding and
// the structs passed between the sequencer and the top level.
package ufef_pkg;

   localparam int NODES    = 1024;
   localparam int NODE_W   = (NODES > 2) ? $clog2(NODES) : 1;
   localparam int SIZE_W   = NODE_W + 1;
   localparam int FIELD_W  = 10;
   localparam int WEIGHT_W = 32;
   localparam int TOTAL_W  = 42;
   localparam int CMP_W    = ((FIELD_W > NODE_W) ? FIELD_W : NODE_W) + 1;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
   localparam logic [NODE_W-1:0]  LAST_NODE = NODE_W'(NODES - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_HALVE,
      ST_SIZE_A,
      ST_SIZE_B,
      ST_RESP
   } ufef_state_type;

   typedef struct packed {
      logic              we;
      logic [NODE_W-1:0] waddr;
      logic [NODE_W-1:0] wdata;
      logic [NODE_W-1:0] raddr;
   } ufef_prt_port_type;

   typedef struct packed {
      logic              we;
      logic [NODE_W-1:0] waddr;
      logic [SIZE_W-1:0] wdata;
      logic [NODE_W-1:0] raddr;
   } ufef_size_port_type;

   typedef struct packed {
      logic               load;
      logic               accepted;
      logic [TOTAL_W-1:0] total_weight;
      logic               final_result;
   } ufef_result_type;

endpackage

### design/ufef_req_if.sv
// Request channel of the union-find edge filter: one graph edge per request.
// Depends on ufef_pkg for the field widths.
interface ufef_req_if;
   import ufef_pkg::*;

   logic                valid;
   logic                ready;
   logic [FIELD_W-1:0]  first_node;
   logic [FIELD_W-1:0]  second_node;
   logic [WEIGHT_W-1:0] edge_weight;
   logic                last_edge;

   modport source (output valid, first_node, second_node, edge_weight, last_edge,
                   input ready);
   modport sink   (input valid, first_node, second_node, edge_weight, last_edge,
                   output ready);
endinterface

### design/ufef_rsp_if.sv
// Response channel of the union-find edge filter: one result per request.
// Depends on ufef_pkg for the field widths.
interface ufef_rsp_if;
   import ufef_pkg::*;

   logic               valid;
   logic               ready;
   logic               accepted;
   logic [TOTAL_W-1:0] total_weight;
   logic               final_result;

   modport source (output valid, accepted, total_weight, final_result, input ready);
   modport sink   (input valid, accepted, total_weight, final_result, output ready);
endinterface

### design/ufef_ram.sv
// Generic simple dual-port RAM: one write and one registered read per cycle.
// No dependencies.
module ufef_ram #(
   parameter int DEPTH  = 1024,
   parameter int WIDTH  = 10,
   parameter int ADDR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### design/ufef_seq.sv
// Sequencer of the union-find edge filter: clearing pass, two root walks
// with path halving, union by size and the running total. Uses ufef_pkg.
module ufef_seq (
   input  logic                         clock,
   input  logic                         reset,
   ufef_req_if.sink                     req_chan,
   input  logic                         slot_free,
   input  logic [ufef_pkg::NODE_W-1:0]  prt_rdata,
   input  logic [ufef_pkg::SIZE_W-1:0]  size_rdata,
   output ufef_pkg::ufef_prt_port_type  prt_port,
   output ufef_pkg::ufef_size_port_type size_port,
   output ufef_pkg::ufef_result_type    result,
   output logic                         clearing
);
   import ufef_pkg::*;

   ufef_state_type       state_ff, state_in;
   logic [NODE_W-1:0]    clr_ff, clr_in;
   logic [NODE_W-1:0]    cur_ff, cur_in;
   logic [NODE_W-1:0]    root_a_ff, root_a_in;
   logic [NODE_W-1:0]    root_b_ff, root_b_in;
   logic [NODE_W-1:0]    sn_ff, sn_in;
   logic [SIZE_W-1:0]    size_a_ff, size_a_in;
   logic [WEIGHT_W-1:0]  weight_ff, weight_in;
   logic [TOTAL_W-1:0]   sum_ff, sum_in;
   logic                 phase_ff, phase_in;
   logic                 acc_ff, acc_in;
   logic                 last_ff, last_in;

   logic                 accept;
   logic                 in_range;
   logic                 at_root;
   logic [TOTAL_W:0]     sum_wide;
   logic [SIZE_W-1:0]    size_joined;

   assign accept   = req_chan.valid && req_chan.ready;
   assign in_range = ({{(CMP_W - FIELD_W){1'b0}}, req_chan.first_node} < CMP_W'(NODES)) &&
                     ({{(CMP_W - FIELD_W){1'b0}}, req_chan.second_node} < CMP_W'(NODES));
   assign at_root     = (prt_rdata == cur_ff);
   assign sum_wide    = {1'b0, sum_ff} + (TOTAL_W + 1)'(weight_ff);
   assign size_joined = size_a_ff + size_rdata;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == LAST_NODE) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = in_range ? ST_WALK : ST_RESP;
            end
         end
         ST_WALK: begin
            if (!at_root) begin
               state_in = ST_HALVE;
            end else if (phase_ff) begin
               state_in = (root_a_ff == cur_ff) ? ST_RESP : ST_SIZE_A;
            end
         end
         ST_HALVE:  state_in = ST_WALK;
         ST_SIZE_A: state_in = ST_SIZE_B;
         ST_SIZE_B: state_in = ST_RESP;
         ST_RESP: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_CLEAR;
      endcase
   end

   // Datapath and memory ports.
   always_comb begin
      clr_in    = clr_ff;
      cur_in    = cur_ff;
      root_a_in = root_a_ff;
      root_b_in = root_b_ff;
      sn_in     = sn_ff;
      size_a_in = size_a_ff;
      weight_in = weight_ff;
      sum_in    = sum_ff;
      phase_in  = phase_ff;
      acc_in    = acc_ff;
      last_in   = last_ff;
      prt_port  = '{we: 1'b0, waddr: cur_ff, wdata: prt_rdata, raddr: prt_rdata};
      size_port = '{we: 1'b0, waddr: root_b_ff, wdata: size_joined, raddr: root_a_ff};
      req_chan.ready = 1'b0;
      clearing       = 1'b0;
      result = '{load: 1'b0, accepted: acc_ff, total_weight: sum_ff,
                 final_result: last_ff};
      case (state_ff)
         ST_CLEAR: begin
            clearing        = 1'b1;
            prt_port.we     = 1'b1;
            prt_port.waddr  = clr_ff;
            prt_port.wdata  = clr_ff;
            size_port.we    = 1'b1;
            size_port.waddr = clr_ff;
            size_port.wdata = SIZE_W'(1);
            clr_in          = clr_ff + NODE_W'(1);
         end
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            prt_port.raddr = NODE_W'(req_chan.first_node);
            if (accept) begin
               cur_in    = NODE_W'(req_chan.first_node);
               sn_in     = NODE_W'(req_chan.second_node);
               weight_in = req_chan.edge_weight;
               last_in   = req_chan.last_edge;
               phase_in  = 1'b0;
               acc_in    = 1'b0;
            end
         end
         ST_WALK: begin
            // prt_rdata is the parent of the current node.
            if (at_root) begin
               if (!phase_ff) begin
                  root_a_in      = cur_ff;
                  phase_in       = 1'b1;
                  cur_in         = sn_ff;
                  prt_port.raddr = sn_ff;
               end else begin
                  root_b_in       = cur_ff;
                  size_port.raddr = root_a_ff;
               end
            end
         end
         ST_HALVE: begin
            // prt_rdata is the grandparent: hang the current node on it and step there.
            prt_port.we = 1'b1;
            cur_in      = prt_rdata;
         end
         ST_SIZE_A: begin
            size_a_in       = size_rdata;
            size_port.raddr = root_b_ff;
         end
         ST_SIZE_B: begin
            // The loser's size is never read again once it stops being a root.
            acc_in          = 1'b1;
            sum_in          = sum_wide[TOTAL_W] ? TOTAL_MAX : sum_wide[TOTAL_W-1:0];
            prt_port.we     = 1'b1;
            size_port.we    = 1'b1;
            if (size_a_ff > size_rdata) begin
               prt_port.waddr  = root_b_ff;
               prt_port.wdata  = root_a_ff;
               size_port.waddr = root_a_ff;
            end else begin
               prt_port.waddr  = root_a_ff;
               prt_port.wdata  = root_b_ff;
               size_port.waddr = root_b_ff;
            end
         end
         ST_RESP: begin
            result.load = slot_free;
         end
         default: begin
            clearing = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         sum_ff   <= '0;
         phase_ff <= 1'b0;
         acc_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         sum_ff   <= sum_in;
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      root_a_ff <= root_a_in;
      root_b_ff <= root_b_in;
      sn_ff     <= sn_in;
      size_a_ff <= size_a_in;
      weight_ff <= weight_in;
      last_ff   <= last_in;
   end

endmodule

### design/kruskal_union_find_edge_filter_unit.sv
// Kruskal edge filter. Each request carries one edge, in ascending weight
// order; the block finds both endpoint roots in a disjoint-set forest held in
// a parent memory and a size memory, accepts the edge when the roots differ,
// unites the sets by size and returns the acceptance flag with the running
// total. After reset a clearing pass writes all NODES (1024) entries of both
// memories before the first request is taken. An edge whose endpoint is out
// of range skips the root walks and is answered as not accepted. Otherwise
// the time an edge takes grows with ha and hb, the path-halving steps of the
// two root walks, because every step of a walk is a read of the single read
// port of the parent memory. A taken edge also passes the two size states. A
// finished result waits in an output register, so the next request is taken
// while the previous result is still pending; the following result then
// stalls the sequencer until the pending one has left.
`include "assert_macros.svh"

module kruskal_union_find_edge_filter_unit (
   input  logic       clock,
   input  logic       reset,
   ufef_req_if.sink   req_chan,
   ufef_rsp_if.source rsp_chan
);
   import ufef_pkg::*;

   ufef_prt_port_type  prt_port;
   ufef_size_port_type size_port;
   ufef_result_type    result;
   logic [NODE_W-1:0]  prt_rdata;
   logic [SIZE_W-1:0]  size_rdata;
   logic               clearing;
   logic               slot_free;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               accepted_ff;
   logic [TOTAL_W-1:0] total_ff;
   logic               final_ff;

   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   ufef_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .slot_free  (slot_free),
      .prt_rdata  (prt_rdata),
      .size_rdata (size_rdata),
      .prt_port   (prt_port),
      .size_port  (size_port),
      .result     (result),
      .clearing   (clearing)
   );

   ufef_ram #(.DEPTH(NODES), .WIDTH(NODE_W), .ADDR_W(NODE_W)) u_parent_ram (
      .clock (clock),
      .we    (prt_port.we),
      .waddr (prt_port.waddr),
      .wdata (prt_port.wdata),
      .raddr (prt_port.raddr),
      .rdata (prt_rdata)
   );

   ufef_ram #(.DEPTH(NODES), .WIDTH(SIZE_W), .ADDR_W(NODE_W)) u_size_ram (
      .clock (clock),
      .we    (size_port.we),
      .waddr (size_port.waddr),
      .wdata (size_port.wdata),
      .raddr (size_port.raddr),
      .rdata (size_rdata)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (result.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.load) begin
         accepted_ff <= result.accepted;
         total_ff    <= result.total_weight;
         final_ff    <= result.final_result;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.accepted     = accepted_ff;
   assign rsp_chan.total_weight = total_ff;
   assign rsp_chan.final_result = final_ff;

   // No request is taken while the memories are being initialized.
   `UFEF_ASSERT_NOW(a_no_req_in_clear, clock, reset, clearing, !req_chan.ready, "request taken during clearing pass")
   // A new result never overwrites one that is still waiting.
   `UFEF_ASSERT_NOW(a_no_overwrite, clock, reset, result.load, !rsp_valid_ff || rsp_chan.ready, "pending result overwritten")
   // Outside the clearing pass no node is ever made its own parent.
   `UFEF_ASSERT_NOW(a_no_self_link, clock, reset, prt_port.we && !clearing, prt_port.waddr != prt_port.wdata, "parent write creates a self link")
   // The running total never decreases from one result to the next.
   `UFEF_ASSERT_NEXT(a_total_monotonic, clock, reset, result.load && !clearing, result.total_weight >= $past(result.total_weight) || !result.load, "running total decreased")

endmodule

### test/kruskal_union_find_edge_filter_unit_test.sv
// Testbench for kruskal_union_find_edge_filter_unit: edge requests in, one result per edge out,
// with a disjoint-set predictor kept alongside the block and checked on every response.
// Depends on ufef_pkg, ufef_req_if, ufef_rsp_if and the block itself.
`timescale 1ns / 1ps

module kruskal_union_find_edge_filter_unit_test;
   import ufef_pkg::*;

   typedef struct packed {
      logic [FIELD_W-1:0]  first_node;
      logic [FIELD_W-1:0]  second_node;
      logic [WEIGHT_W-1:0] edge_weight;
      logic                last_edge;
   } graph_edge_type;

   typedef struct packed {
      logic               accepted;
      logic [TOTAL_W-1:0] total_weight;
      logic               final_result;
   } tree_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ufef_req_if req_bus ();
   ufef_rsp_if rsp_bus ();

   kruskal_union_find_edge_filter_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always #2 clock = ~clock;

   // Forest as the block should hold it.
   logic [NODE_W-1:0]  parent_link [NODES];
   logic [SIZE_W-1:0]  tree_size [NODES];
   logic [TOTAL_W-1:0] mst_total;

   tree_result_type expected_results [$];

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int long_hold_cycles   = 0;
   int mismatch_count     = 0;
   int edges_checked      = 0;
   int edges_taken        = 0;
   int tie_merges         = 0;
   int halving_writes     = 0;
   logic [WEIGHT_W:0]  ascending_weight = '0;
   graph_edge_type     previous_edge = '0;

   function automatic void reset_forest_model();
      for (int i = 0; i < NODES; i++) begin
         parent_link[i] = NODE_W'(i);
         tree_size[i]   = SIZE_W'(1);
      end
      mst_total = '0;
   endfunction

   function automatic logic [NODE_W-1:0] find_root_halving(input logic [NODE_W-1:0] node);
      logic [NODE_W-1:0] cur;
      cur = node;
      while (parent_link[cur] != cur) begin
         if (parent_link[cur] != parent_link[parent_link[cur]])
            halving_writes++;
         parent_link[cur] = parent_link[parent_link[cur]];
         cur = parent_link[cur];
      end
      return cur;
   endfunction

   function automatic tree_result_type take_edge(input graph_edge_type e);
      tree_result_type   r;
      logic [NODE_W-1:0] root_a;
      logic [NODE_W-1:0] root_b;
      logic [TOTAL_W:0]  sum;
      r = '0;
      if (int'(e.first_node) < NODES && int'(e.second_node) < NODES) begin
         root_a = find_root_halving(e.first_node[NODE_W-1:0]);
         root_b = find_root_halving(e.second_node[NODE_W-1:0]);
         if (root_a != root_b) begin
            r.accepted = 1'b1;
            sum = {1'b0, mst_total} + e.edge_weight;
            mst_total = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOTAL_W-1:0];
            if (tree_size[root_a] == tree_size[root_b])
               tie_merges++;
            if (tree_size[root_a] > tree_size[root_b]) begin
               parent_link[root_b] = root_a;
               tree_size[root_a]   = tree_size[root_a] + tree_size[root_b];
               tree_size[root_b]   = '0;
            end else begin
               parent_link[root_a] = root_b;
               tree_size[root_b]   = tree_size[root_b] + tree_size[root_a];
               tree_size[root_a]   = '0;
            end
         end
      end
      r.total_weight = mst_total;
      r.final_result = e.last_edge;
      return r;
   endfunction

   // Responses are checked before the request of the same edge is predicted; a result
   // can never leave in the cycle its own request is taken.
   always @(posedge clock) begin
      tree_result_type want;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            edges_checked++;
            if (rsp_bus.accepted)
               edges_taken++;
            if (expected_results.size() == 0) begin
               $error("unexpected result: accepted %0d total_weight %0d final_result %0d",
                      rsp_bus.accepted, rsp_bus.total_weight, rsp_bus.final_result);
               mismatch_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_bus.accepted !== want.accepted) begin
                  $error("accepted: expected %0d, got %0d", want.accepted, rsp_bus.accepted);
                  mismatch_count++;
               end
               if (rsp_bus.total_weight !== want.total_weight) begin
                  $error("total_weight: expected %0d, got %0d",
                         want.total_weight, rsp_bus.total_weight);
                  mismatch_count++;
               end
               if (rsp_bus.final_result !== want.final_result) begin
                  $error("final_result: expected %0d, got %0d",
                         want.final_result, rsp_bus.final_result);
                  mismatch_count++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready)
            expected_results.insert(expected_results.size(),
                                    take_edge({req_bus.first_node, req_bus.second_node,
                                               req_bus.edge_weight, req_bus.last_edge}));
      end
   end

   // Receiver: random stalls, plus an occasional long hold-off counted down here.
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            long_hold_cycles--;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
         end
      end
   end

   // Called at a rising edge; returns at the edge where the request was taken.
   task automatic send_edge(input graph_edge_type e);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < sender_idle_pct)
         gap++;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.first_node  <= e.first_node;
      req_bus.second_node <= e.second_node;
      req_bus.edge_weight <= e.edge_weight;
      req_bus.last_edge   <= e.last_edge;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
   endtask

   task automatic send_pair(input int a, input int b, input logic [WEIGHT_W-1:0] w,
                            input logic last);
      send_edge({FIELD_W'(a), FIELD_W'(b), w, last});
   endtask

   // The checker records the last request at the same edge this is called from, so the
   // queue is only looked at from the next edge on.
   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0)
         @(posedge clock);
   endtask

   function automatic graph_edge_type random_edge();
      graph_edge_type e;
      int             kind;
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
         e.first_node  = FIELD_W'($urandom);
         e.second_node = FIELD_W'($urandom);
      end else if (kind < 80) begin
         // A small cluster closes cycles quickly and makes for long root walks.
         e.first_node  = FIELD_W'($urandom_range(0, 63));
         e.second_node = FIELD_W'($urandom_range(0, 63));
      end else if (kind < 90) begin
         e.first_node  = FIELD_W'($urandom);
         e.second_node = e.first_node;
      end else if (kind < 95) begin
         e.first_node  = previous_edge.second_node;
         e.second_node = previous_edge.first_node;
      end else begin
         e.first_node  = $urandom_range(0, 1) ? '1 : '0;
         e.second_node = $urandom_range(0, 1) ? '1 : '0;
      end
      // Mostly ascending weights, as a sorted edge list would give, with some noise.
      if ($urandom_range(0, 9) == 0) begin
         e.edge_weight = $urandom;
      end else begin
         ascending_weight = ascending_weight + $urandom_range(0, 1 << 20);
         if (ascending_weight[WEIGHT_W])
            ascending_weight = {1'b0, {WEIGHT_W{1'b1}}};
         e.edge_weight = ascending_weight[WEIGHT_W-1:0];
      end
      e.last_edge   = ($urandom_range(0, 19) == 0);
      previous_edge = e;
      return e;
   endfunction

   task automatic send_random_edges(input int count);
      for (int i = 0; i < count; i++)
         send_edge(random_edge());
   endtask

   task automatic test_directed_unions();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      send_pair(0, 1023, 32'h0, 1'b0);
      send_pair(1023, 0, 32'hFFFF_FFFF, 1'b0);   // same tree, rejected
      send_pair(5, 5, 32'h1, 1'b0);              // self loop
      send_pair(0, 0, 32'h2, 1'b0);
      send_pair(1023, 1023, 32'hFFFF_FFFF, 1'b1);
      send_pair(2, 3, 32'hFFFF_FFFF, 1'b0);      // size tie: first goes under second
      send_pair(4, 3, 32'h10, 1'b0);             // first smaller
      send_pair(2, 6, 32'h11, 1'b0);             // first strictly larger
      send_pair(10, 11, 32'h20, 1'b0);
      send_pair(12, 13, 32'h21, 1'b0);
      send_pair(10, 12, 32'h22, 1'b0);
      send_pair(14, 15, 32'h23, 1'b0);
      send_pair(16, 17, 32'h24, 1'b0);
      send_pair(14, 16, 32'h25, 1'b0);
      send_pair(10, 14, 32'h26, 1'b0);           // builds a three-level path
      send_pair(10, 20, 32'h27, 1'b0);           // the walk from 10 halves its path
      send_pair(12, 10, 32'h28, 1'b0);
      send_pair(3, 17, 32'h29, 1'b0);
      send_pair(15, 6, 32'h2A, 1'b0);
      send_pair(1022, 1021, 32'hFFFF_FFFF, 1'b1);
      wait_for_results();
   endtask

   task automatic test_random_no_idling();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      send_random_edges(250);
   endtask

   task automatic test_random_sender_idle();
      sender_idle_pct    = 54;
      receiver_stall_pct = 0;
      send_random_edges(250);
   endtask

   task automatic test_random_receiver_stall();
      sender_idle_pct    = 0;
      receiver_stall_pct = 54;
      send_random_edges(250);
   endtask

   task automatic test_random_both_idle();
      sender_idle_pct    = 7;
      receiver_stall_pct = 7;
      send_random_edges(250);
   endtask

   // The output holds off long enough that the block fills and stops taking requests;
   // afterwards the sender pauses until every result is back.
   task automatic test_output_backpressure();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      long_hold_cycles   = 400;
      send_random_edges(40);
      wait_for_results();
   endtask

   initial begin
      req_bus.valid       <= 1'b0;
      req_bus.first_node  <= '0;
      req_bus.second_node <= '0;
      req_bus.edge_weight <= '0;
      req_bus.last_edge   <= 1'b0;
      reset_forest_model();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_unions();
      test_random_no_idling();
      test_output_backpressure();
      test_random_sender_idle();
      test_random_receiver_stall();
      test_random_both_idle();

      wait_for_results();
      repeat (60) @(posedge clock);
      $display("Checked %0d edges: %0d joined trees, %0d unions on equal sizes.",
               edges_checked, edges_taken, tie_merges);
      $display("Root walks rewrote %0d parent links; final tree cost %0d.",
               halving_writes, mst_total);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

### kruskal_union_find_edge_filter_unit.f
+incdir+design
design/ufef_pkg.sv
design/ufef_req_if.sv
design/ufef_rsp_if.sv
design/ufef_ram.sv
design/ufef_seq.sv
design/kruskal_union_find_edge_filter_unit.sv
test/kruskal_union_find_edge_filter_unit_test.sv
